>>> design/ctiop_pkg.sv
// Shared types, constants and helper functions of the cue sheet track offset parser.
package ctiop_pkg;

	localparam int TEXT_W   = 8;
	localparam int TRACK_W  = 7;
	localparam int OFFSET_W = 30;
	localparam int FRAME_W  = 19;
	localparam int MATCH_W  = 3;
	localparam int STAMP_W  = 3;
	localparam int SKIP_W   = 2;
	localparam int WEIGHT_W = 16;
	localparam int DIGIT_W  = 4;
	localparam int BPF_W    = 12;
	localparam int APB_DW   = 32;
	localparam int APB_AW   = 3;

	localparam int PAT_LEN   = 8;
	localparam int INDEX_LEN = 5;

	localparam logic [BPF_W-1:0]   BYTES_PER_FRAME = 12'd2352;
	localparam logic [TRACK_W-1:0] TRACK_RESET     = 7'd1;
	localparam logic [TRACK_W-1:0] TRACK_MAX       = 7'd99;
	localparam logic [TEXT_W-1:0]  CHAR_ZERO       = 8'h30;
	localparam logic [TEXT_W-1:0]  CHAR_NINE       = 8'h39;
	localparam logic [SKIP_W-1:0]  SKIP_SEPARATOR  = 2'd0;
	localparam logic [SKIP_W-1:0]  SKIP_FOUR       = 2'd3;

	// Register index, taken from the word address of the configuration port.
	localparam logic REG_TRACK_NUMBER = 1'b0;

	localparam logic [TEXT_W-1:0] TRACK_PREFIX [6] = '{"T", "R", "A", "C", "K", " "};
	localparam logic [TEXT_W-1:0] INDEX01_PAT [PAT_LEN] =
		'{"I", "N", "D", "E", "X", " ", "0", "1"};

	typedef enum logic [2:0] {
		PH_TRACK = 3'd0,
		PH_IDX01 = 3'd1,
		PH_SKIP1 = 3'd2,
		PH_START = 3'd3,
		PH_IDX   = 3'd4,
		PH_SKIP4 = 3'd5,
		PH_END   = 3'd6,
		PH_DONE  = 3'd7
	} ctiop_phase_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] start_offset;
		logic [OFFSET_W-1:0] end_offset;
		logic                start_found;
		logic                end_found;
		logic                format_error;
	} ctiop_result_t;

	// Frame weight of each character place of an MM:SS:FF time; colons weigh nothing.
	function automatic logic [WEIGHT_W-1:0] place_weight(input logic [STAMP_W-1:0] p);
		logic [WEIGHT_W-1:0] w;
		case (p)
			3'd0:    w = 16'd45000;
			3'd1:    w = 16'd4500;
			3'd3:    w = 16'd750;
			3'd4:    w = 16'd75;
			3'd6:    w = 16'd10;
			3'd7:    w = 16'd1;
			default: w = 16'd0;
		endcase
		return w;
	endfunction

endpackage

>>> design/ctiop_regs.sv
// Configuration register file with its APB-style access port.
module ctiop_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ctiop_pkg::APB_AW-1:0]  paddr,
	input  logic [ctiop_pkg::APB_DW-1:0]  pwdata,
	output logic [ctiop_pkg::APB_DW-1:0]  prdata,
	output logic                          pready,
	output logic [ctiop_pkg::TRACK_W-1:0] track_number
);
	import ctiop_pkg::*;

	logic               wr_en;
	logic               reg_idx;
	logic [TRACK_W-1:0] track_q;

	assign reg_idx = paddr[APB_AW-1];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= TRACK_RESET;
		end else if (wr_en && reg_idx == REG_TRACK_NUMBER) begin
			track_q <= pwdata[TRACK_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_TRACK_NUMBER) begin
			prdata = {{(APB_DW-TRACK_W){1'b0}}, track_q};
		end
	end

	assign track_number = track_q;

endmodule

>>> design/ctiop_core.sv
// Per-byte search and time parsing engine that builds one result per sheet.
module ctiop_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [ctiop_pkg::TEXT_W-1:0]  text_byte,
	input  logic                          end_of_text,
	input  logic [ctiop_pkg::TRACK_W-1:0] track_number,
	output logic                          emit,
	output ctiop_pkg::ctiop_result_t      result
);
	import ctiop_pkg::*;

	ctiop_phase_t          phase_q, phase_d;
	logic [MATCH_W-1:0]    mc_q, mc_d;
	logic [SKIP_W-1:0]     skip_q, skip_d;
	logic [STAMP_W-1:0]    stamp_q, stamp_d;
	logic [FRAME_W-1:0]    frame_q, frame_d;
	logic [OFFSET_W-1:0]   hold_q, hold_d;
	logic                  seen_q, seen_d;
	logic                  sent_q, sent_d;
	logic                  bad_q, bad_d;
	logic                  emit_end;

	// Two decimal digits of the track number: tens by reciprocal multiply.
	logic [TRACK_W+7:0]    tens_prod;
	logic [DIGIT_W-1:0]    tens;
	logic [TRACK_W-1:0]    tens_x10;
	logic [TRACK_W-1:0]    ones;
	logic                  track_ok;
	logic [TEXT_W-1:0]     track_pat [PAT_LEN];

	logic [TEXT_W-1:0]     pat_char;
	logic [TEXT_W-1:0]     pat_first;
	logic [MATCH_W:0]      pat_len;
	logic [MATCH_W:0]      mc_new;
	logic                  match_done;

	logic                  is_digit;
	logic                  digit_place;
	logic [DIGIT_W-1:0]    digit;
	logic [WEIGHT_W-1:0]   weight;
	logic [WEIGHT_W+DIGIT_W-1:0] contrib;
	logic [FRAME_W-1:0]    frame_acc;
	logic [FRAME_W-1:0]    frame_last;
	logic [FRAME_W+BPF_W-1:0] offset_full;
	logic [OFFSET_W-1:0]   offset;

	assign tens_prod = {8'd0, track_number} * {{TRACK_W{1'b0}}, 8'd205};
	assign tens      = tens_prod[TRACK_W+7:11];
	assign tens_x10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
	assign ones      = track_number - tens_x10;
	assign track_ok  = track_number <= TRACK_MAX;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			track_pat[i] = TRACK_PREFIX[i];
		end
		track_pat[6] = CHAR_ZERO + {4'd0, tens};
		track_pat[7] = CHAR_ZERO + {4'd0, ones[DIGIT_W-1:0]};
	end

	// One shared matcher; the phase picks the pattern and its length.
	always_comb begin
		if (phase_q == PH_TRACK) begin
			pat_char  = track_pat[mc_q];
			pat_first = TRACK_PREFIX[0];
		end else begin
			pat_char  = INDEX01_PAT[mc_q];
			pat_first = INDEX01_PAT[0];
		end
		pat_len = (phase_q == PH_IDX) ? (MATCH_W+1)'(INDEX_LEN) : (MATCH_W+1)'(PAT_LEN);
		if (text_byte == pat_char) begin
			mc_new = {1'b0, mc_q} + 1'b1;
		end else begin
			mc_new = {{MATCH_W{1'b0}}, text_byte == pat_first};
		end
		match_done = mc_new == pat_len;
	end

	// Time digits: a non-digit counts as zero and is flagged.
	assign is_digit    = text_byte >= CHAR_ZERO && text_byte <= CHAR_NINE;
	assign digit       = is_digit ? text_byte[DIGIT_W-1:0] : '0;
	assign weight      = place_weight(stamp_q);
	assign digit_place = weight != '0;
	assign contrib     = digit * weight;
	assign frame_acc   = frame_q + contrib[FRAME_W-1:0];
	assign frame_last  = frame_q + {{(FRAME_W-DIGIT_W){1'b0}}, digit};
	assign offset_full = {{BPF_W{1'b0}}, frame_last} * {{FRAME_W{1'b0}}, BYTES_PER_FRAME};
	assign offset      = offset_full[OFFSET_W-1:0];

	always_comb begin
		phase_d  = phase_q;
		mc_d     = mc_q;
		skip_d   = skip_q;
		stamp_d  = stamp_q;
		frame_d  = frame_q;
		hold_d   = hold_q;
		seen_d   = seen_q;
		sent_d   = sent_q;
		bad_d    = bad_q;
		emit_end = 1'b0;
		case (phase_q)
			PH_TRACK: begin
				if (track_ok) begin
					mc_d = mc_new[MATCH_W-1:0];
					if (match_done) begin
						mc_d    = '0;
						phase_d = PH_IDX01;
					end
				end
			end
			PH_IDX01, PH_IDX: begin
				mc_d = mc_new[MATCH_W-1:0];
				if (match_done) begin
					mc_d = '0;
					if (phase_q == PH_IDX01) begin
						phase_d = PH_SKIP1;
						skip_d  = SKIP_SEPARATOR;
					end else begin
						phase_d = PH_SKIP4;
						skip_d  = SKIP_FOUR;
					end
				end
			end
			PH_SKIP1, PH_SKIP4: begin
				if (skip_q == '0) begin
					phase_d = (phase_q == PH_SKIP1) ? PH_START : PH_END;
					stamp_d = '0;
					frame_d = '0;
				end else begin
					skip_d = skip_q - 1'b1;
				end
			end
			PH_START, PH_END: begin
				if (digit_place) begin
					frame_d = frame_acc;
					if (!is_digit) begin
						bad_d = 1'b1;
					end
				end
				stamp_d = stamp_q + 1'b1;
				if (stamp_q == STAMP_W'(PAT_LEN - 1)) begin
					if (phase_q == PH_START) begin
						hold_d  = offset;
						seen_d  = 1'b1;
						phase_d = PH_IDX;
						mc_d    = '0;
					end else begin
						emit_end = 1'b1;
						sent_d   = 1'b1;
						phase_d  = PH_DONE;
					end
				end
			end
			default: begin
			end
		endcase

		emit = fire && (emit_end || (end_of_text && !sent_q));
		result.start_offset = seen_d ? hold_d : '0;
		result.end_offset   = emit_end ? offset : '0;
		result.start_found  = seen_d;
		result.end_found    = emit_end;
		result.format_error = bad_d;

		// The last byte of a sheet rearms the block for the next one.
		if (end_of_text) begin
			phase_d = PH_TRACK;
			mc_d    = '0;
			skip_d  = '0;
			stamp_d = '0;
			frame_d = '0;
			hold_d  = '0;
			seen_d  = 1'b0;
			sent_d  = 1'b0;
			bad_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TRACK;
			mc_q    <= '0;
			skip_q  <= '0;
			stamp_q <= '0;
			frame_q <= '0;
			hold_q  <= '0;
			seen_q  <= 1'b0;
			sent_q  <= 1'b0;
			bad_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			mc_q    <= mc_d;
			skip_q  <= skip_d;
			stamp_q <= stamp_d;
			frame_q <= frame_d;
			hold_q  <= hold_d;
			seen_q  <= seen_d;
			sent_q  <= sent_d;
			bad_q   <= bad_d;
		end
	end

endmodule

>>> design/cue_track_index_offset_parser_unit.sv
// Top level of the cue sheet parser that finds one track's start and end byte offsets.
//
// The text channel carries one cue sheet character per request, with end_of_text set on the
// last character of a sheet. The block looks for "TRACK nn" of the configured track, then
// "INDEX 01", skips one separator and reads an MM:SS:FF time; it then looks for the next
// "INDEX", skips four characters and reads the second time. Times become CD frames and then
// byte offsets (frames times 2352). The result channel carries one request per sheet: on the
// character that completes the second time, or else on the end_of_text character, with the
// found flags telling what was parsed. Characters after a result are dropped until
// end_of_text, which rearms the block.
// Throughput is one character per cycle while the result channel does not stall. A character is
// taken into an input register, is processed by the parser once the output register is free,
// and its result is written into the output register as it is processed. The parser's state
// update is combinational, with one constant multiply for the offset. The input register keeps
// taking characters while a result waits in the output register; when the receiver stalls
// with a result pending, the input register holds one character and text_ready drops until
// the result is taken. Reset clears all parsing state and sets track_number to one. The
// track_number register sits at byte address 0 of the configuration port. The user must
// write it only while idle; the block itself does not enforce this.
module cue_track_index_offset_parser_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           text_valid,
	output logic                           text_ready,
	input  logic [ctiop_pkg::TEXT_W-1:0]   text_byte,
	input  logic                           end_of_text,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [ctiop_pkg::OFFSET_W-1:0] start_offset,
	output logic [ctiop_pkg::OFFSET_W-1:0] end_offset,
	output logic                           start_found,
	output logic                           end_found,
	output logic                           format_error,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ctiop_pkg::APB_AW-1:0]   paddr,
	input  logic [ctiop_pkg::APB_DW-1:0]   pwdata,
	output logic [ctiop_pkg::APB_DW-1:0]   prdata,
	output logic                           pready
);
	import ctiop_pkg::*;

	logic               valid_s1;
	logic [TEXT_W-1:0]  byte_s1;
	logic               eot_s1;
	logic               out_valid_q;
	ctiop_result_t      result_q;
	ctiop_result_t      core_result;
	logic               core_emit;
	logic               out_free;
	logic               fire;
	logic [TRACK_W-1:0] track_number;

	// The output register can take a new result when empty or when its result leaves now.
	assign out_free   = !out_valid_q || result_ready;
	assign fire       = valid_s1 && out_free;
	assign text_ready = !valid_s1 || out_free;

	ctiop_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.track_number (track_number)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	ctiop_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.text_byte    (byte_s1),
		.end_of_text  (eot_s1),
		.track_number (track_number),
		.emit         (core_emit),
		.result       (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= core_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (core_emit) begin
			result_q <= core_result;
		end
	end

	assign result_valid = out_valid_q;
	assign start_offset = result_q.start_offset;
	assign end_offset   = result_q.end_offset;
	assign start_found  = result_q.start_found;
	assign end_found    = result_q.end_found;
	assign format_error = result_q.format_error;

	// A result is produced only for a character being processed into a free output slot.
	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		core_emit |-> (fire && out_free))
		else $error("result produced while the output register was occupied");

	// The end time is only reached after the start time.
	a_end_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!end_found || start_found))
		else $error("end offset reported without a start offset");

	// Offsets that were not found read as zero.
	a_unfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((start_found || start_offset == '0) &&
			(end_found || end_offset == '0)))
		else $error("offset nonzero while its found flag is clear");

	// A result produced by the parser is offered on the result channel at the next edge.
	a_emit_offered: assert property (@(posedge clk) disable iff (!arst_n)
		core_emit |=> result_valid)
		else $error("produced result was not offered on the result channel");

endmodule

>>> dv/tb_cue_track_index_offset_parser_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench that feeds cue sheets to the track offset parser and checks its results.
module tb_cue_track_index_offset_parser_unit;
	import ctiop_pkg::*;

	localparam int CLK_HALF_NS  = 10;
	localparam int RESET_CYCLES = 4;
	// Cycles with no request moving on either channel before the run is called hung.
	localparam int STALL_LIMIT  = 2000;
	// Edges waited after the last result, so that a character still inside the block is processed.
	localparam int DRAIN_CYCLES = 4;
	localparam int IDLE_PCT     = 37;
	localparam int PHASE_CHARS  = 240;
	localparam int PHASES       = 7;
	localparam int MAX_PRINTED  = 40;
	// Word index past the last register; a write there must change nothing.
	localparam int SPARE_REG    = 1;

	localparam logic [7:0]  DIGIT_LO     = 8'h30;
	localparam logic [7:0]  DIGIT_HI     = 8'h39;
	localparam logic [7:0]  COLON_CHAR   = 8'h3A;
	localparam logic [7:0]  SPACE_CHAR   = 8'h20;
	localparam int unsigned SECTOR_BYTES = 2352;
	localparam logic [63:0] INDEX_TEXT   = "INDEX 01";

	// One character request as it waits for the text channel.
	typedef struct {
		logic [7:0] ch;
		logic       last;
	} cue_char_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                text_valid   = 1'b0;
	logic                text_ready;
	logic [TEXT_W-1:0]   text_byte    = '0;
	logic                end_of_text  = 1'b0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic [OFFSET_W-1:0] start_offset;
	logic [OFFSET_W-1:0] end_offset;
	logic                start_found;
	logic                end_found;
	logic                format_error;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [APB_AW-1:0]   paddr        = '0;
	logic [APB_DW-1:0]   pwdata       = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	// Characters waiting for the driver, and the sheet being assembled before it is queued.
	cue_char_t  cue_chars_pending [$];
	cue_char_t  next_char;
	logic [7:0] sheet_buf [$];

	// Parser outcomes predicted for the sheets sent so far, oldest first.
	ctiop_result_t offsets_due [$];
	ctiop_result_t want;

	// Our own copy of the track register and of the parsing state.
	logic [TRACK_W-1:0] track_cfg   = 7'd1;
	ctiop_phase_t       scan_phase  = PH_TRACK;
	int                 match_n     = 0;
	int                 skip_n      = 0;
	int                 stamp_pos   = 0;
	int unsigned        frames      = 0;
	int unsigned        start_bytes = 0;
	bit                 have_start  = 1'b0;
	bit                 sent        = 1'b0;
	bit                 bad         = 1'b0;

	// When set, neither side inserts idle cycles.
	bit steady = 1'b0;

	int errors        = 0;
	int quiet_cycles  = 0;
	int chars_taken   = 0;
	int results_seen  = 0;
	int both_found    = 0;
	int sheets_queued = 0;
	int phase_chars   = 0;
	int settings_used = 0;

	cue_track_index_offset_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.start_offset(start_offset),
		.end_offset(end_offset),
		.start_found(start_found),
		.end_found(end_found),
		.format_error(format_error),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#CLK_HALF_NS clk = 1'b1;
		#CLK_HALF_NS clk = 1'b0;
	end

	task automatic flag_mismatch(input string what);
		if (errors < MAX_PRINTED)
			$display("MISMATCH at %0t ns: %s", $time, what);
		errors++;
	endtask

	// ---------------------------------------------------------------------------------------
	// Predictor. Each accepted character advances our copy of the parser; when the parser
	// would close a sheet, the outcome is queued for the monitor.
	// ---------------------------------------------------------------------------------------

	function automatic void rearm_scan();
		scan_phase  = PH_TRACK;
		match_n     = 0;
		skip_n      = 0;
		stamp_pos   = 0;
		frames      = 0;
		start_bytes = 0;
		have_start  = 1'b0;
		sent        = 1'b0;
		bad         = 1'b0;
	endfunction

	// Steps a search for the first len characters of pat (first character in the top byte).
	// On a mismatch the search restarts, and the offending character still counts as a
	// one-character match when it equals the first character of the pattern.
	function automatic bit pattern_hit(input logic [7:0] ch, input logic [63:0] pat, input int len);
		if (match_n < len && ch == pat[63 - 8 * match_n -: 8])
			match_n++;
		else
			match_n = (ch == pat[63:56]) ? 1 : 0;
		if (match_n >= len) begin
			match_n = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Takes one character of an MM:SS:FF time and adds its weight in CD frames. The colon
	// places weigh nothing and are never checked; a non-digit in a digit place counts as zero
	// and marks the sheet as badly formatted. True once the eighth character is in.
	function automatic bit stamp_take(input logic [7:0] ch);
		int unsigned w;
		case (stamp_pos)
			0: w = 45000;
			1: w = 4500;
			3: w = 750;
			4: w = 75;
			6: w = 10;
			7: w = 1;
			default: w = 0;
		endcase
		if (w != 0) begin
			if (ch >= DIGIT_LO && ch <= DIGIT_HI)
				frames += w * (ch - DIGIT_LO);
			else
				bad = 1'b1;
		end
		stamp_pos++;
		if (stamp_pos >= 8) begin
			stamp_pos = 0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Builds the one result of a sheet; offsets that were not found read as zero.
	function automatic ctiop_result_t close_sheet(input bit tail_ok, input int unsigned tail_bytes);
		ctiop_result_t r;
		r.start_offset = have_start ? start_bytes[OFFSET_W-1:0] : '0;
		r.end_offset   = tail_ok ? tail_bytes[OFFSET_W-1:0] : '0;
		r.start_found  = have_start;
		r.end_found    = tail_ok;
		r.format_error = bad;
		sent       = 1'b1;
		scan_phase = PH_DONE;
		return r;
	endfunction

	function automatic void scan_cue_byte(input logic [7:0] ch, input logic last);
		logic [63:0] track_text;
		track_text = {"TRACK ", 8'(DIGIT_LO + track_cfg / 10), 8'(DIGIT_LO + track_cfg % 10)};
		case (scan_phase)
			PH_TRACK: begin
				// A track number past 99 has no two-digit line, so the search never starts.
				if (track_cfg <= TRACK_MAX) begin
					if (pattern_hit(ch, track_text, 8))
						scan_phase = PH_IDX01;
				end
			end
			PH_IDX01: begin
				if (pattern_hit(ch, INDEX_TEXT, 8)) begin
					scan_phase = PH_SKIP1;
					skip_n     = 1;
				end
			end
			PH_SKIP1, PH_SKIP4: begin
				if (skip_n > 0)
					skip_n--;
				if (skip_n == 0) begin
					scan_phase = ctiop_phase_t'(scan_phase + 3'd1);
					stamp_pos  = 0;
					frames     = 0;
				end
			end
			PH_START: begin
				if (stamp_take(ch)) begin
					start_bytes = frames * SECTOR_BYTES;
					have_start  = 1'b1;
					scan_phase  = PH_IDX;
					match_n     = 0;
				end
			end
			PH_IDX: begin
				// Only the word INDEX is sought here; the four characters after it are skipped.
				if (pattern_hit(ch, INDEX_TEXT, 5)) begin
					scan_phase = PH_SKIP4;
					skip_n     = 4;
				end
			end
			PH_END: begin
				if (stamp_take(ch))
					offsets_due.push_back(close_sheet(1'b1, frames * SECTOR_BYTES));
			end
			default: ;
		endcase
		// The last character of a sheet closes it if nothing was sent yet, then rearms.
		if (last) begin
			if (!sent)
				offsets_due.push_back(close_sheet(1'b0, 0));
			rearm_scan();
		end
	endfunction

	// ---------------------------------------------------------------------------------------
	// Text channel driver. A request, once offered, is held until the block takes it; after
	// that the next character goes out at once or after a random idle stretch.
	// ---------------------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (text_valid && text_ready) begin
				scan_cue_byte(text_byte, end_of_text);
				chars_taken++;
			end
			if (!text_valid || text_ready) begin
				if (cue_chars_pending.size() != 0 &&
						(steady || $urandom_range(99) >= IDLE_PCT)) begin
					next_char = cue_chars_pending.pop_front();
					text_valid  <= 1'b1;
					text_byte   <= next_char.ch;
					end_of_text <= next_char.last;
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// Result channel monitor. Every result taken is matched field by field against the
	// oldest predicted outcome; the receiver stalls at random unless steady is set.
	// ---------------------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				results_seen++;
				if (start_found && end_found)
					both_found++;
				if (offsets_due.size() == 0) begin
					flag_mismatch("result request with no sheet outcome pending");
				end else begin
					want = offsets_due.pop_front();
					if (start_offset !== want.start_offset)
						flag_mismatch($sformatf("start_offset %0d, predicted %0d",
							start_offset, want.start_offset));
					if (end_offset !== want.end_offset)
						flag_mismatch($sformatf("end_offset %0d, predicted %0d",
							end_offset, want.end_offset));
					if (start_found !== want.start_found)
						flag_mismatch($sformatf("start_found %b, predicted %b",
							start_found, want.start_found));
					if (end_found !== want.end_found)
						flag_mismatch($sformatf("end_found %b, predicted %b",
							end_found, want.end_found));
					if (format_error !== want.format_error)
						flag_mismatch($sformatf("format_error %b, predicted %b",
							format_error, want.format_error));
				end
			end
			result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: a long run of cycles in which no request moves means the block is stuck.
	always @(posedge clk) begin
		if ((text_valid && text_ready) || (result_valid && result_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no request moved for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Configuration port: setup cycle, then access cycle until pready; the register takes the
	// value at that edge. Writes only happen while the parser is idle.
	// ---------------------------------------------------------------------------------------
	task automatic apb_write(input int unsigned index, input logic [APB_DW-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(4 * index);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (index == REG_TRACK_NUMBER)
			track_cfg = value[TRACK_W-1:0];
	endtask

	// Waits until every queued character is taken and every predicted result has come back,
	// then lets the pipeline empty, since a character that closes nothing may still be inside.
	task automatic drain();
		do @(negedge clk);
		while (cue_chars_pending.size() != 0 || text_valid || offsets_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------------------------
	// Sheet generation.
	// ---------------------------------------------------------------------------------------
	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			sheet_buf.push_back(s[i]);
	endtask

	task automatic add_noise(input int n);
		repeat (n) sheet_buf.push_back(8'($urandom_range(255)));
	endtask

	// An MM:SS:FF time with random digits. Now and then a digit place gets a stray character,
	// and a colon place gets anything at all.
	task automatic add_stamp();
		for (int p = 0; p < 8; p++) begin
			if (p == 2 || p == 5) begin
				if ($urandom_range(7) == 0)
					sheet_buf.push_back(8'($urandom_range(255)));
				else
					sheet_buf.push_back(COLON_CHAR);
			end else if ($urandom_range(15) == 0) begin
				sheet_buf.push_back(8'($urandom_range(255)));
			end else begin
				sheet_buf.push_back(8'(DIGIT_LO + $urandom_range(9)));
			end
		end
	endtask

	task automatic add_index(input int k);
		add_text($sformatf("INDEX %02d", k));
		if ($urandom_range(9) == 0)
			sheet_buf.push_back(8'($urandom_range(255)));
		else
			sheet_buf.push_back(SPACE_CHAR);
		add_stamp();
		if ($urandom_range(1) == 1)
			add_text("\n");
	endtask

	// Moves the assembled sheet to the driver, marking its last character. Some sheets are
	// cut short so that the text ends in the middle of a search or a time.
	task automatic queue_sheet(input bit may_cut);
		cue_char_t c;
		int keep;
		keep = sheet_buf.size();
		if (may_cut && keep > 1 && $urandom_range(6) == 0)
			keep = $urandom_range(1, keep);
		for (int i = 0; i < keep; i++) begin
			c.ch   = sheet_buf[i];
			c.last = (i == keep - 1);
			cue_chars_pending.push_back(c);
		end
		sheet_buf.delete();
		sheets_queued++;
		phase_chars += keep;
	endtask

	// Mostly well-formed sheets with random content: other tracks first, then the wanted track
	// with its INDEX 01 and usually a following INDEX. The rest are loose fragments or noise.
	task automatic build_sheet();
		int style;
		int tgt;
		style = $urandom_range(99);
		tgt = (track_cfg <= TRACK_MAX) ? int'(track_cfg) : $urandom_range(99);
		if ($urandom_range(3) == 0)
			add_noise($urandom_range(1, 5));
		if (style < 75) begin
			repeat ($urandom_range(2)) begin
				add_text($sformatf("TRACK %02d\n", $urandom_range(99)));
				add_index(1);
			end
			// A doubled first letter checks that a failed match restarts on that letter.
			if ($urandom_range(7) == 0)
				add_text("T");
			add_text($sformatf("TRACK %02d", tgt));
			if ($urandom_range(1) == 1)
				add_text(" AUDIO\n");
			if ($urandom_range(3) == 0)
				add_index(0);
			if ($urandom_range(7) == 0)
				add_text("I");
			add_index(1);
			if ($urandom_range(4) != 0)
				add_index($urandom_range(1, 2));
			// Characters after the result must be ignored.
			if ($urandom_range(2) == 0)
				add_noise($urandom_range(1, 4));
		end else if (style < 90) begin
			repeat ($urandom_range(2, 6)) begin
				case ($urandom_range(3))
					0: add_text($sformatf("TRACK %02d", tgt));
					1: begin
						add_text("INDEX 0");
						if ($urandom_range(1) == 1)
							add_text("1 ");
					end
					2: add_stamp();
					default: add_noise($urandom_range(1, 3));
				endcase
			end
		end else begin
			add_noise($urandom_range(1, 12));
		end
		queue_sheet(1'b1);
	endtask

	// ---------------------------------------------------------------------------------------
	// Test sequence. Later phases first write a register while idle (phase 1 the spare one); each
	// phase queues its sheets and drains. Phase 0 opens with two directed sheets on the reset track.
	// ---------------------------------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: apb_write(SPARE_REG, $urandom);
				2: apb_write(REG_TRACK_NUMBER, 32'd0);
				3: apb_write(REG_TRACK_NUMBER, 32'd99);
				// Low bits all ones: track 127, above the last two-digit number.
				4: apb_write(REG_TRACK_NUMBER, $urandom | 32'h7F);
				5: apb_write(REG_TRACK_NUMBER,
					($urandom & 32'hFFFF_FF80) | $urandom_range(2, 98));
				6: apb_write(REG_TRACK_NUMBER, 32'd10);
				default: ;
			endcase
			@(negedge clk);
			// One whole phase runs with both sides ready every cycle.
			steady = (p == 5);
			settings_used++;
			if (p == 0) begin
				// A one-character sheet: its result reports nothing found.
				sheet_buf.push_back(8'hFF);
				queue_sheet(1'b0);
				// Restarts on a doubled first letter, non-digits in digit places, an odd
				// colon place, the end time after INDEX plus four, and trailing characters.
				sheet_buf.push_back(8'h00);
				add_text("TTRACK 01IINDEX 01 0a:5xQ99INDEX#01#99:59:74XY");
				queue_sheet(1'b0);
			end
			phase_chars = 0;
			while (phase_chars < PHASE_CHARS)
				build_sheet();
			drain();
		end

		if (offsets_due.size() != 0)
			flag_mismatch($sformatf("%0d sheet outcomes never arrived", offsets_due.size()));
		$display("Sent %0d characters in %0d sheets under %0d track settings (0, 99 and 127 among them).",
			chars_taken, sheets_queued, settings_used);
		$display("Checked %0d results, %0d of them with both offsets found.",
			results_seen, both_found);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> cue_track_index_offset_parser_unit.f
design/ctiop_pkg.sv
design/ctiop_regs.sv
design/ctiop_core.sv
design/cue_track_index_offset_parser_unit.sv
dv/tb_cue_track_index_offset_parser_unit.sv
